>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ECD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication
`define ECD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Types and codes shared by the call dispatcher controller and datapath.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int FLOOR_W = 5;
  localparam int KIND_W  = 2;
  localparam int DIR_W   = 2;

  // Input operations
  localparam logic OP_CALL   = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GO     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

  // Travel directions
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // Modes
  localparam logic MODE_IDLE = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the input transfer
    logic exec;   // apply the item, finish unless a search is needed
    logic scan;   // search the call bitmap and report
  } ecd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic needs_scan;
  } ecd_sts_t;

endpackage

>>> src/elevator_call_dispatcher.sv
// ----------------------------------------------------------------------------
// elevator_call_dispatcher
// Collective-control call dispatcher: call bitmap, target and direction.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  --------+-------------------+--------------------------------------------
//  in_     | start / busy      | in_opcode, in_floor
//  out_    | out_valid strobe  | out_kind, out_target_floor, out_heading,
//          |                   | out_position
//  cfg_    | cfg_we            | cfg_wdata (start floor)
//
//  A call or a rejected or ignored item passes the load and execute steps
//  from transfer to result strobe; an arrival while running also passes the
//  scan step, the nearest-call search over the bitmap. busy is high from
//  transfer until the result is issued. Reset is synchronous and needs no
//  clearing pass. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module elevator_call_dispatcher #(
  parameter int NUM_FLOORS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [ecd_pkg::FLOOR_W-1:0]  in_floor,
  input  logic                         cfg_we,
  input  logic [ecd_pkg::FLOOR_W-1:0]  cfg_wdata,
  output logic                         out_valid,
  output logic [ecd_pkg::KIND_W-1:0]   out_kind,
  output logic [ecd_pkg::FLOOR_W-1:0]  out_target_floor,
  output logic [ecd_pkg::DIR_W-1:0]    out_heading,
  output logic [ecd_pkg::FLOOR_W-1:0]  out_position
);

  `include "assert_macros.svh"

  ecd_pkg::ecd_cmd_t cmd;
  ecd_pkg::ecd_sts_t sts;

  // Sequencer
  ecd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath
  ecd_dpath #(
    .NUM_FLOORS (NUM_FLOORS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_floor         (in_floor),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_target_floor (out_target_floor),
    .out_heading      (out_heading),
    .out_position     (out_position)
  );

  // Checks
  `ECD_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `ECD_ASSERT_IMP(a_result_after_work, out_valid, $past(busy))
  `ECD_ASSERT_IMP(a_go_has_target, out_valid && (out_kind == ecd_pkg::KIND_GO), out_target_floor != '0)
  `ECD_ASSERT_IMP(a_stop_no_heading, out_valid && (out_kind == ecd_pkg::KIND_STOP), (out_heading == ecd_pkg::DIR_NONE) && (out_target_floor == '0))

endmodule

>>> src/ecd_ctrl.sv
// ----------------------------------------------------------------------------
// ecd_ctrl
// Sequencer: load an item, execute it, optionally run the call search.
// ----------------------------------------------------------------------------
module ecd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ecd_pkg::ecd_sts_t sts,
  output ecd_pkg::ecd_cmd_t cmd,
  output logic             busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.needs_scan ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/ecd_dpath.sv
// ----------------------------------------------------------------------------
// ecd_dpath
// Call bitmap, cabin state, nearest-call search and result registers.
// ----------------------------------------------------------------------------
module ecd_dpath #(
  parameter int NUM_FLOORS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ecd_pkg::ecd_cmd_t                    cmd,
  output ecd_pkg::ecd_sts_t                    sts,
  input  logic                                 in_opcode,
  input  logic [ecd_pkg::FLOOR_W-1:0]          in_floor,
  input  logic                                 cfg_we,
  input  logic [ecd_pkg::FLOOR_W-1:0]          cfg_wdata,
  output logic                                 out_valid,
  output logic [ecd_pkg::KIND_W-1:0]           out_kind,
  output logic [ecd_pkg::FLOOR_W-1:0]          out_target_floor,
  output logic [ecd_pkg::DIR_W-1:0]            out_heading,
  output logic [ecd_pkg::FLOOR_W-1:0]          out_position
);

  localparam int IDX_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;

  // Latched item
  logic                          op_r;
  logic [ecd_pkg::FLOOR_W-1:0]   fl_r;

  // Dispatcher state
  logic [NUM_FLOORS-1:0]         pend_r;
  logic [ecd_pkg::FLOOR_W-1:0]   cur_r;
  logic [ecd_pkg::FLOOR_W-1:0]   tgt_r;
  logic [ecd_pkg::DIR_W-1:0]     dir_r;
  logic                          mode_r;

  // Result registers
  logic                          out_valid_r;
  logic [ecd_pkg::KIND_W-1:0]    out_kind_r;
  logic [ecd_pkg::FLOOR_W-1:0]   out_tgt_r;
  logic [ecd_pkg::DIR_W-1:0]     out_dir_r;
  logic [ecd_pkg::FLOOR_W-1:0]   out_pos_r;

  logic                          fl_ok;
  logic                          cfg_ok;
  logic [NUM_FLOORS-1:0]         fl_bit;
  logic [ecd_pkg::FLOOR_W-1:0]   call_tgt;
  logic [ecd_pkg::DIR_W-1:0]     call_dir;

  logic [NUM_FLOORS-1:0]         up_set;
  logic [NUM_FLOORS-1:0]         dn_set;
  logic [NUM_FLOORS-1:0]         dn_rev;
  logic [NUM_FLOORS-1:0]         up_oh;
  logic [NUM_FLOORS-1:0]         dn_oh;
  logic [IDX_W-1:0]              up_idx;
  logic [IDX_W-1:0]              dn_idx;
  logic [ecd_pkg::FLOOR_W-1:0]   up_fl;
  logic [ecd_pkg::FLOOR_W-1:0]   dn_fl;
  logic [ecd_pkg::FLOOR_W-1:0]   found;

  // Range checks and the one-hot bit of the latched floor
  always_comb begin
    fl_ok  = (fl_r != '0) && (int'(fl_r) <= NUM_FLOORS);
    cfg_ok = (cfg_wdata != '0) && (int'(cfg_wdata) <= NUM_FLOORS);
    for (int i = 0; i < NUM_FLOORS; i++) begin
      fl_bit[i] = (i + 1 == int'(fl_r));
    end
  end

  assign sts.needs_scan = fl_ok && (op_r == ecd_pkg::OP_ARRIVE) &&
                          (mode_r == ecd_pkg::MODE_RUN);

  // Call: retarget when none is set or the floor lies ahead
  always_comb begin
    call_tgt = (tgt_r == '0) ? fl_r : tgt_r;
    if (((dir_r == ecd_pkg::DIR_UP) && (cur_r < fl_r)) ||
        ((dir_r == ecd_pkg::DIR_DOWN) && (cur_r > fl_r))) begin
      call_tgt = fl_r;
    end
    call_dir = (cur_r < call_tgt) ? ecd_pkg::DIR_UP : ecd_pkg::DIR_DOWN;
  end

  // Search: lowest call above the cabin, highest call below it
  always_comb begin
    for (int i = 0; i < NUM_FLOORS; i++) begin
      up_set[i] = pend_r[i] && (i >= int'(cur_r));
      dn_set[i] = pend_r[i] && (i < int'(cur_r) - 1);
    end
    for (int i = 0; i < NUM_FLOORS; i++) begin
      dn_rev[i] = dn_set[NUM_FLOORS-1-i];
    end
    up_oh = up_set & (~up_set + NUM_FLOORS'(1));
    dn_oh = dn_rev & (~dn_rev + NUM_FLOORS'(1));
    up_idx = '0;
    dn_idx = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (up_oh[i]) up_idx = up_idx | IDX_W'(i);
      if (dn_oh[i]) dn_idx = dn_idx | IDX_W'(i);
    end
    up_fl = (up_set != '0) ? ecd_pkg::FLOOR_W'(int'(up_idx) + 1) : '0;
    dn_fl = (dn_set != '0) ? ecd_pkg::FLOOR_W'(NUM_FLOORS - int'(dn_idx)) : '0;
    if (cur_r > tgt_r) begin
      found = (dn_fl != '0) ? dn_fl : up_fl;
    end else begin
      found = (up_fl != '0) ? up_fl : dn_fl;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      fl_r <= in_floor;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.exec && !sts.needs_scan) begin
      out_pos_r <= cur_r;
      if (!fl_ok) begin
        out_kind_r <= ecd_pkg::KIND_REJECT;
        out_tgt_r  <= '0;
        out_dir_r  <= dir_r;
      end else if (op_r == ecd_pkg::OP_CALL) begin
        out_kind_r <= ecd_pkg::KIND_GO;
        out_tgt_r  <= fl_r;
        out_dir_r  <= call_dir;
      end else begin
        out_kind_r <= ecd_pkg::KIND_NONE;
        out_tgt_r  <= '0;
        out_dir_r  <= dir_r;
      end
    end else if (cmd.scan) begin
      out_pos_r <= cur_r;
      if (found != '0) begin
        out_kind_r <= ecd_pkg::KIND_GO;
        out_tgt_r  <= found;
        out_dir_r  <= (cur_r < found) ? ecd_pkg::DIR_UP : ecd_pkg::DIR_DOWN;
      end else begin
        out_kind_r <= ecd_pkg::KIND_STOP;
        out_tgt_r  <= '0;
        out_dir_r  <= ecd_pkg::DIR_NONE;
      end
    end
  end

  // Dispatcher state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cur_r       <= ecd_pkg::FLOOR_W'(1);
      tgt_r       <= '0;
      dir_r       <= ecd_pkg::DIR_NONE;
      mode_r      <= ecd_pkg::MODE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.exec && !sts.needs_scan) || cmd.scan;
      if (cfg_we && cfg_ok && (mode_r == ecd_pkg::MODE_IDLE)) begin
        cur_r <= cfg_wdata;
      end
      if (cmd.exec && fl_ok) begin
        if (op_r == ecd_pkg::OP_CALL) begin
          mode_r <= ecd_pkg::MODE_RUN;
          pend_r <= pend_r | fl_bit;
          tgt_r  <= call_tgt;
          dir_r  <= call_dir;
        end else if (mode_r == ecd_pkg::MODE_RUN) begin
          cur_r  <= fl_r;
          pend_r <= pend_r & ~fl_bit;
        end
      end
      if (cmd.scan) begin
        if (found != '0) begin
          tgt_r <= found;
          dir_r <= (cur_r < found) ? ecd_pkg::DIR_UP : ecd_pkg::DIR_DOWN;
        end else begin
          mode_r <= ecd_pkg::MODE_IDLE;
          tgt_r  <= '0;
          dir_r  <= ecd_pkg::DIR_NONE;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_target_floor = out_tgt_r;
  assign out_heading      = out_dir_r;
  assign out_position     = out_pos_r;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Call dispatcher testbench
// Drives calls and arrivals into elevator_call_dispatcher through the
// start/busy handshake and predicts every result from a cycle-free model of
// the call bitmap, target, direction and mode. Each strobed result is
// checked field by field against the oldest prediction. Directed items come
// first, then three random phases with different sender gap rates, with
// start floor writes made only once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

localparam int N_FLOORS = 16;

typedef struct packed {
  logic [ecd_pkg::KIND_W-1:0]  kind;
  logic [ecd_pkg::FLOOR_W-1:0] target_floor;
  logic [ecd_pkg::DIR_W-1:0]   heading;
  logic [ecd_pkg::FLOOR_W-1:0] position;
} dispatch_result_t;

class dispatch_tracker;
  logic [N_FLOORS-1:0]         calls;
  logic [ecd_pkg::FLOOR_W-1:0] home_floor;
  logic [ecd_pkg::FLOOR_W-1:0] cur_floor;
  logic [ecd_pkg::FLOOR_W-1:0] cur_target;
  logic [ecd_pkg::DIR_W-1:0]   dir;
  logic                        mode;
  dispatch_result_t            expected_reports[$];
  int                          mismatches;
  int                          failures;

  function new();
    home_floor = 5'd1;
    calls      = '0;
    cur_floor  = home_floor;
    cur_target = '0;
    dir        = ecd_pkg::DIR_NONE;
    mode       = ecd_pkg::MODE_IDLE;
    mismatches = 0;
    failures   = 0;
  endfunction

  function bit floor_valid(logic [ecd_pkg::FLOOR_W-1:0] f);
    return (f >= 1) && (f <= N_FLOORS);
  endfunction

  // Ignore out-of-range values; place the cabin only when idle
  function void write_start_floor(logic [ecd_pkg::FLOOR_W-1:0] v);
    if (floor_valid(v)) begin
      home_floor = v;
      if (mode == ecd_pkg::MODE_IDLE) cur_floor = v;
    end
  endfunction

  function logic [ecd_pkg::FLOOR_W-1:0] scan_down(logic [ecd_pkg::FLOOR_W-1:0] from);
    int f;
    for (f = from; f >= 1; f--)
      if (calls[f-1]) return f[ecd_pkg::FLOOR_W-1:0];
    return '0;
  endfunction

  function logic [ecd_pkg::FLOOR_W-1:0] scan_up(logic [ecd_pkg::FLOOR_W-1:0] from);
    int f;
    for (f = from; f <= N_FLOORS; f++)
      if (calls[f-1]) return f[ecd_pkg::FLOOR_W-1:0];
    return '0;
  endfunction

  // Advance the dispatcher state by one transfer and queue its result
  function void note_item(logic op, logic [ecd_pkg::FLOOR_W-1:0] fl);
    dispatch_result_t            res;
    logic [ecd_pkg::FLOOR_W-1:0] found;
    res.kind         = ecd_pkg::KIND_NONE;
    res.target_floor = '0;
    if (!floor_valid(fl)) begin
      res.kind = ecd_pkg::KIND_REJECT;
    end else if (op == ecd_pkg::OP_CALL) begin
      mode = ecd_pkg::MODE_RUN;
      calls[fl-1] = 1'b1;
      if (cur_target == 0) cur_target = fl;
      if ((dir == ecd_pkg::DIR_UP && cur_floor < fl) ||
          (dir == ecd_pkg::DIR_DOWN && cur_floor > fl))
        cur_target = fl;
      dir = (cur_floor < cur_target) ? ecd_pkg::DIR_UP : ecd_pkg::DIR_DOWN;
      res.kind         = ecd_pkg::KIND_GO;
      res.target_floor = fl;
    end else if (mode == ecd_pkg::MODE_RUN) begin
      cur_floor = fl;
      calls[fl-1] = 1'b0;
      // Search ahead first, then the other way
      if (cur_floor > cur_target) begin
        found = scan_down(cur_floor);
        if (found == 0) found = scan_up(cur_floor);
      end else begin
        found = scan_up(cur_floor);
        if (found == 0) found = scan_down(cur_floor);
      end
      if (found != 0) begin
        cur_target = found;
        dir = (cur_floor < cur_target) ? ecd_pkg::DIR_UP : ecd_pkg::DIR_DOWN;
        res.kind         = ecd_pkg::KIND_GO;
        res.target_floor = found;
      end else begin
        mode       = ecd_pkg::MODE_IDLE;
        cur_target = '0;
        dir        = ecd_pkg::DIR_NONE;
        res.kind   = ecd_pkg::KIND_STOP;
      end
    end
    res.heading  = dir;
    res.position = cur_floor;
    expected_reports.push_back(res);
  endfunction

  function void check_result(dispatch_result_t got);
    dispatch_result_t want;
    if (expected_reports.size() == 0) begin
      failures++;
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: kind=%0d target=%0d heading=%0d position=%0d",
                 got.kind, got.target_floor, got.heading, got.position);
      return;
    end
    want = expected_reports.pop_front();
    if (got.kind !== want.kind || got.target_floor !== want.target_floor ||
        got.heading !== want.heading || got.position !== want.position) begin
      failures++;
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected kind=%0d target=%0d heading=%0d position=%0d,",
                  " got kind=%0d target=%0d heading=%0d position=%0d"},
                 want.kind, want.target_floor, want.heading, want.position,
                 got.kind, got.target_floor, got.heading, got.position);
    end
  endfunction
endclass

module testbench;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        start     = 1'b0;
  logic                        in_opcode = ecd_pkg::OP_CALL;
  logic [ecd_pkg::FLOOR_W-1:0] in_floor  = '0;
  logic                        cfg_we    = 1'b0;
  logic [ecd_pkg::FLOOR_W-1:0] cfg_wdata = '0;
  logic                        busy;
  logic                        out_valid;
  logic [ecd_pkg::KIND_W-1:0]  out_kind;
  logic [ecd_pkg::FLOOR_W-1:0] out_target_floor;
  logic [ecd_pkg::DIR_W-1:0]   out_heading;
  logic [ecd_pkg::FLOOR_W-1:0] out_position;

  dispatch_tracker             tracker;
  int                          idle_pct;
  int                          sent;
  int                          phase;
  logic                        op;
  logic [ecd_pkg::FLOOR_W-1:0] fl;

  always #1 clk = ~clk;

  elevator_call_dispatcher #(.NUM_FLOORS(N_FLOORS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_floor         (in_floor),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_target_floor (out_target_floor),
    .out_heading      (out_heading),
    .out_position     (out_position)
  );

  // Check every strobed result
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_result('{out_kind, out_target_floor, out_heading, out_position});
  end

  // Hold the item until the transfer, then note it
  task automatic send_item(input logic item_op,
                           input logic [ecd_pkg::FLOOR_W-1:0] item_floor);
    start     <= 1'b1;
    in_opcode <= item_op;
    in_floor  <= item_floor;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_item(item_op, item_floor);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop start, then hold off until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_floor(input logic [ecd_pkg::FLOOR_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    tracker.write_start_floor(v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly calls and arrivals at the live target, some stray and bad floors
  task automatic pick_item(output logic item_op,
                           output logic [ecd_pkg::FLOOR_W-1:0] item_floor);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      item_op    = 1'($urandom_range(0, 1));
      item_floor = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
    end else if (r < 55) begin
      item_op    = ecd_pkg::OP_CALL;
      item_floor = 5'($urandom_range(1, N_FLOORS));
    end else begin
      item_op = ecd_pkg::OP_ARRIVE;
      if (tracker.mode == ecd_pkg::MODE_RUN && tracker.cur_target != 0 &&
          $urandom_range(0, 3) != 0)
        item_floor = tracker.cur_target;
      else
        item_floor = 5'($urandom_range(1, N_FLOORS));
    end
  endtask

  initial begin
    #400000;
    $display("FAIL elevator_call_dispatcher");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rejects and an ignored arrival from the reset state
    send_item(ecd_pkg::OP_CALL, 5'd0);
    send_item(ecd_pkg::OP_ARRIVE, 5'd5);
    send_item(ecd_pkg::OP_ARRIVE, 5'd31);
    send_item(ecd_pkg::OP_CALL, 5'd17);
    drain_results();

    // Top floor placement, then values that must be dropped
    write_start_floor(5'd16);
    write_start_floor(5'd0);
    write_start_floor(5'd31);
    write_start_floor(5'd21);

    // Down trip with a retarget, a call at the cabin floor and a stray arrival
    send_item(ecd_pkg::OP_CALL, 5'd1);
    send_item(ecd_pkg::OP_CALL, 5'd16);
    send_item(ecd_pkg::OP_CALL, 5'd8);
    send_item(ecd_pkg::OP_ARRIVE, 5'd8);
    send_item(ecd_pkg::OP_ARRIVE, 5'd16);
    send_item(ecd_pkg::OP_ARRIVE, 5'd3);
    send_item(ecd_pkg::OP_CALL, 5'd10);
    send_item(ecd_pkg::OP_ARRIVE, 5'd1);
    send_item(ecd_pkg::OP_ARRIVE, 5'd10);
    send_item(ecd_pkg::OP_ARRIVE, 5'd4);
    send_item(ecd_pkg::OP_ARRIVE, 5'd0);
    drain_results();

    // Bottom floor placement, then a write while running leaves the cabin
    write_start_floor(5'd1);
    send_item(ecd_pkg::OP_CALL, 5'd15);
    send_item(ecd_pkg::OP_CALL, 5'd2);
    send_item(ecd_pkg::OP_CALL, 5'd16);
    drain_results();
    write_start_floor(5'd9);
    send_item(ecd_pkg::OP_ARRIVE, 5'd2);
    send_item(ecd_pkg::OP_ARRIVE, 5'd15);
    send_item(ecd_pkg::OP_ARRIVE, 5'd16);
    send_item(ecd_pkg::OP_CALL, 5'd31);
    drain_results();

    // Random phases: sender gaps at 14 %, then 50 %, then none
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 50 : 0;
      drain_results();
      write_start_floor((phase == 0) ? 5'd16 : (phase == 1) ? 5'd1 :
                        5'($urandom_range(1, N_FLOORS)));
      sent = 0;
      while (sent < 417) begin
        pick_item(op, fl);
        send_item(op, fl);
        sent++;
        if ($urandom_range(0, 59) == 0) begin
          drain_results();
          write_start_floor(5'($urandom_range(0, 31)));
        end else if ($urandom_range(0, 99) < idle_pct) begin
          pause_sender(int'($urandom_range(1, 4)));
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    tracker.failures += tracker.expected_reports.size();
    if (tracker.failures == 0)
      $display("PASS elevator_call_dispatcher");
    else
      $display("FAIL elevator_call_dispatcher");
    $finish;
  end

endmodule

>>> elevator_call_dispatcher.f
+incdir+src
src/ecd_pkg.sv
src/ecd_ctrl.sv
src/ecd_dpath.sv
src/elevator_call_dispatcher.sv
tb/sv/testbench.sv
